/* rtl/differential_drive_ramp_controller_top_defines.svh */
// Assertion macros shared by the drive controller RTL.
// No dependencies; every user supplies i_clk and i_rst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_RAMP_CONTROLLER_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_RAMP_CONTROLLER_TOP_DEFINES_SVH

// Condition holds at every edge out of reset.
`define DDRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DDRC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ddrc_pkg.sv */
// Shared types, codes, constants and helper functions of the drive controller.
// No dependencies.
package ddrc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NUM_MODES     = 8;
    localparam int IDX_BITS      = 3;
    localparam int PWR_BITS      = 7;

    localparam logic [31:0] READ_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_READ = 2'd2,
        CMD_IDLE = 2'd3
    } t_cmd;

    localparam logic [3:0] MODE_HALT   = 4'd0;
    localparam logic [3:0] MODE_FWD    = 4'd1;
    localparam logic [3:0] MODE_BWD    = 4'd2;
    localparam logic [3:0] MODE_SPIN_R = 4'd3;
    localparam logic [3:0] MODE_SPIN_L = 4'd4;
    localparam logic [3:0] MODE_FWD_R  = 4'd5;
    localparam logic [3:0] MODE_FWD_L  = 4'd6;
    localparam logic [3:0] MODE_BWD_R  = 4'd7;
    localparam logic [3:0] MODE_BWD_L  = 4'd8;
    localparam logic [3:0] MODE_MAX    = MODE_BWD_L;

    localparam logic [2:0] CFG_CRUISE = 3'd0;
    localparam logic [2:0] CFG_SPIN   = 3'd1;
    localparam logic [2:0] CFG_INNER  = 3'd2;
    localparam logic [2:0] CFG_START  = 3'd3;
    localparam logic [2:0] CFG_DOWN   = 3'd4;
    localparam logic [2:0] CFG_PERIOD = 3'd5;

    localparam logic [6:0] RST_CRUISE = 7'd75;
    localparam logic [6:0] RST_SPIN   = 7'd50;
    localparam logic [6:0] RST_INNER  = 7'd8;
    localparam logic [6:0] RST_START  = 7'd30;
    localparam logic [6:0] RST_DOWN   = 7'd5;
    localparam logic [7:0] RST_PERIOD = 8'd50;

    localparam logic [3:0] BRIDGE_RIGHT = 4'b0011;
    localparam logic [3:0] BRIDGE_LEFT  = 4'b1100;

    typedef struct packed {
        logic                upd;
        logic                rd;
        logic [IDX_BITS-1:0] idx;
    } t_tot_req;

    function automatic logic [3:0] bridge_of(input logic [3:0] mode);
        logic [3:0] b;
        unique case (mode) inside
            MODE_FWD, MODE_FWD_R, MODE_FWD_L: b = 4'd5;
            MODE_BWD, MODE_BWD_R, MODE_BWD_L: b = 4'd10;
            MODE_SPIN_R:                      b = 4'd6;
            MODE_SPIN_L:                      b = 4'd9;
            default:                          b = 4'd0;
        endcase
        return b;
    endfunction

    // Returns {right goal, left goal}.
    function automatic logic [2*PWR_BITS-1:0] goals_of(
        input logic [3:0]          mode,
        input logic [PWR_BITS-1:0] cruise,
        input logic [PWR_BITS-1:0] spin,
        input logic [PWR_BITS-1:0] inner
    );
        logic [2*PWR_BITS-1:0] g;
        unique case (mode) inside
            MODE_FWD, MODE_BWD:       g = {cruise, cruise};
            MODE_SPIN_R, MODE_SPIN_L: g = {spin, spin};
            MODE_FWD_R, MODE_BWD_R:   g = {inner, cruise};
            MODE_FWD_L, MODE_BWD_L:   g = {cruise, inner};
            default:                  g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [PWR_BITS-1:0] ramp_step(
        input logic [PWR_BITS-1:0] lvl,
        input logic [PWR_BITS-1:0] goal,
        input logic [PWR_BITS-1:0] down,
        input logic [PWR_BITS-1:0] start
    );
        logic [PWR_BITS:0]   up;
        logic [PWR_BITS-1:0] res;
        up = '0;
        if (lvl == goal) begin
            res = lvl;
        end else if (goal < lvl) begin
            res = (lvl < down) ? '0 : lvl - down;
        end else begin
            up = (lvl < start) ? {1'b0, start} : {1'b0, lvl} + 1'b1;
            if (up > {1'b0, goal}) begin
                up = {1'b0, goal};
            end
            res = up[PWR_BITS-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/differential_drive_ramp_controller_top.sv */
// Top level of the differential-drive ramp controller: stream ports, pipeline, output register.
// Depends on ddrc_pkg, ddrc_ctrl and ddrc_totals.
//
// Usage:
//   Slave stream carries one command per transaction: tuser holds the command
//   (tick, move, read mode time, idle), tdata holds direction, duration and report mode.
//   Master stream returns exactly one result per command: mode, both wheel powers,
//   bridge bits and the mode time (zero except for reads).
//   The plain write port loads the six control registers; write only while no command
//   is in flight.
//   A result passes through the memory-stage register and then the output register
//   before it appears on the master stream.
//   Throughput: one command per cycle unless the receiver stalls; the motion state
//   updates at acceptance and the per-mode totals memory does one read-modify-write
//   per command, with a forward path when consecutive commands touch the same entry.
//   Receiver stall: the output register holds the result; at most one further command
//   is taken into the memory stage, then s_axis_tready drops until the result is taken.
//   Reset (synchronous, active low): halted, zero power, registers at defaults, totals
//   read as zero at once through per-entry valid flags; no clearing pass.
`include "differential_drive_ramp_controller_top_defines.svh"

module differential_drive_ramp_controller_top #(
    parameter int TIME_BITS = ddrc_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // direction[3:0], duration_ms[27:4], report_mode[31:28]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // mode_now[3:0], right_power[10:4], left_power[17:11],
                                       // bridge_bits[21:18], mode_time_ms[53:22], zero[55:54]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import ddrc_pkg::*;

    logic                 accept, adv, s1_go;
    logic [3:0]           c_mode, c_bridge;
    logic [PWR_BITS-1:0]  c_rpow, c_lpow;
    t_tot_req             c_req;
    logic [TIME_BITS-1:0] c_delta;
    logic [31:0]          report;

    logic                 r_s1_valid;
    logic [3:0]           r_s1_mode, r_s1_bridge;
    logic [PWR_BITS-1:0]  r_s1_rpow, r_s1_lpow;
    logic                 r_out_valid;
    logic [55:0]          r_out_data;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && adv;
    assign s_axis_tready = !r_s1_valid || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ddrc_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .i_dir      (s_axis_tdata[3:0]),
        .i_dur      (s_axis_tdata[27:4]),
        .i_rep      (s_axis_tdata[31:28]),
        .o_mode     (c_mode),
        .o_rpow     (c_rpow),
        .o_lpow     (c_lpow),
        .o_bridge   (c_bridge),
        .o_req      (c_req),
        .o_delta    (c_delta)
    );

    ddrc_totals #(
        .TIME_BITS (TIME_BITS)
    ) u_totals (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_req    (c_req),
        .i_delta  (c_delta),
        .i_go     (s1_go),
        .o_report (report)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode   <= c_mode;
            r_s1_rpow   <= c_rpow;
            r_s1_lpow   <= c_lpow;
            r_s1_bridge <= c_bridge;
        end
        if (s1_go) begin
            r_out_data <= {2'b00, report, r_s1_bridge, r_s1_lpow, r_s1_rpow, r_s1_mode};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `DDRC_ASSERT_NEXT(a_out_kept, r_out_valid && !m_axis_tready, r_out_valid,
        "stalled result dropped")
    `DDRC_ASSERT_NEXT(a_s1_kept, r_s1_valid && !adv, r_s1_valid && $stable(r_s1_mode),
        "memory stage lost its transaction")

endmodule

/* rtl/ddrc_ctrl.sv */
// Motion state and settings: mode, levels, goals, bridge bits, run time, timers.
// Depends on ddrc_pkg; issues totals requests to ddrc_totals.
`include "differential_drive_ramp_controller_top_defines.svh"

module ddrc_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_idx,
    input  logic [7:0]                       i_cfg_data,
    input  logic                             i_accept,
    input  ddrc_pkg::t_cmd                   i_cmd,
    input  logic [3:0]                       i_dir,
    input  logic [23:0]                      i_dur,
    input  logic [3:0]                       i_rep,
    output logic [3:0]                       o_mode,
    output logic [ddrc_pkg::PWR_BITS-1:0]    o_rpow,
    output logic [ddrc_pkg::PWR_BITS-1:0]    o_lpow,
    output logic [3:0]                       o_bridge,
    output ddrc_pkg::t_tot_req               o_req,
    output logic [TIME_BITS-1:0]             o_delta
);
    import ddrc_pkg::*;

    logic [PWR_BITS-1:0]  r_cruise, r_spin, r_inner, r_start, r_down;
    logic [7:0]           r_period;

    logic [3:0]           r_mode, n_mode;
    logic [PWR_BITS-1:0]  r_rlvl, n_rlvl, r_llvl, n_llvl;
    logic [PWR_BITS-1:0]  r_rgoal, n_rgoal, r_lgoal, n_lgoal;
    logic [3:0]           r_bridge, n_bridge;
    logic [23:0]          r_rem, n_rem;
    logic [7:0]           r_pc, n_pc;
    logic [TIME_BITS-1:0] r_since, n_since;

    logic [TIME_BITS-1:0] since_inc;
    logic [7:0]           pc_inc;
    logic [3:0]           bridge_tmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= RST_CRUISE;
            r_spin   <= RST_SPIN;
            r_inner  <= RST_INNER;
            r_start  <= RST_START;
            r_down   <= RST_DOWN;
            r_period <= RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRUISE: r_cruise <= i_cfg_data[PWR_BITS-1:0];
                CFG_SPIN:   r_spin   <= i_cfg_data[PWR_BITS-1:0];
                CFG_INNER:  r_inner  <= i_cfg_data[PWR_BITS-1:0];
                CFG_START:  r_start  <= i_cfg_data[PWR_BITS-1:0];
                CFG_DOWN:   r_down   <= i_cfg_data[PWR_BITS-1:0];
                CFG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_rlvl     = r_rlvl;
        n_llvl     = r_llvl;
        n_rgoal    = r_rgoal;
        n_lgoal    = r_lgoal;
        n_bridge   = r_bridge;
        n_rem      = r_rem;
        n_pc       = r_pc;
        n_since    = r_since;
        o_req      = '0;
        o_delta    = '0;
        since_inc  = (r_since == '1) ? r_since : r_since + 1'b1;
        pc_inc     = r_pc + 8'd1;
        bridge_tmp = r_bridge;
        unique case (i_cmd)
            CMD_TICK: begin
                n_since = since_inc;
                n_rem   = (r_rem != '0) ? r_rem - 24'd1 : r_rem;
                if (pc_inc >= r_period) begin
                    n_pc = '0;
                    if (n_rem == '0 && r_mode != MODE_HALT) begin
                        o_req.upd = 1'b1;
                        o_req.idx = IDX_BITS'(r_mode - 4'd1);
                        o_delta   = since_inc;
                        n_mode    = MODE_HALT;
                        n_since   = '0;
                        n_rgoal   = '0;
                        n_lgoal   = '0;
                    end
                    n_rlvl = ramp_step(r_rlvl, n_rgoal, r_down, r_start);
                    n_llvl = ramp_step(r_llvl, n_lgoal, r_down, r_start);
                    if (n_rlvl == '0) begin
                        bridge_tmp = bridge_tmp & ~BRIDGE_RIGHT;
                    end
                    if (n_llvl == '0) begin
                        bridge_tmp = bridge_tmp & ~BRIDGE_LEFT;
                    end
                    n_bridge = bridge_tmp;
                end else begin
                    n_pc = pc_inc;
                end
            end
            CMD_MOVE: begin
                if (i_dir <= MODE_MAX && i_dir != r_mode) begin
                    if (r_mode != MODE_HALT) begin
                        o_req.upd = 1'b1;
                        o_req.idx = IDX_BITS'(r_mode - 4'd1);
                        o_delta   = r_since;
                    end
                    n_since            = '0;
                    n_mode             = i_dir;
                    {n_rgoal, n_lgoal} = goals_of(i_dir, r_cruise, r_spin, r_inner);
                    if (i_dir != MODE_HALT) begin
                        n_bridge = bridge_of(i_dir);
                    end
                end
                if (i_dir != MODE_HALT && i_dir <= MODE_MAX && i_dur != '0) begin
                    n_rem = i_dur;
                end
            end
            CMD_READ: begin
                if (i_rep != MODE_HALT && i_rep <= MODE_MAX) begin
                    o_req.rd  = 1'b1;
                    o_req.idx = IDX_BITS'(i_rep - 4'd1);
                    o_delta   = (r_mode == i_rep) ? r_since : '0;
                end
            end
            CMD_IDLE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HALT;
            r_rlvl   <= '0;
            r_llvl   <= '0;
            r_rgoal  <= '0;
            r_lgoal  <= '0;
            r_bridge <= '0;
            r_rem    <= '0;
            r_pc     <= '0;
            r_since  <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_rlvl   <= n_rlvl;
            r_llvl   <= n_llvl;
            r_rgoal  <= n_rgoal;
            r_lgoal  <= n_lgoal;
            r_bridge <= n_bridge;
            r_rem    <= n_rem;
            r_pc     <= n_pc;
            r_since  <= n_since;
        end
    end

    assign o_mode   = n_mode;
    assign o_rpow   = n_rlvl;
    assign o_lpow   = n_llvl;
    assign o_bridge = n_bridge;

    `DDRC_ASSERT_ALWAYS(a_mode_range, r_mode <= MODE_MAX, "motion mode out of range")
    `DDRC_ASSERT_IMPL(a_halt_goals, r_mode == MODE_HALT, r_rgoal == '0 && r_lgoal == '0,
        "halted with nonzero goal")

endmodule

/* rtl/ddrc_totals.sv */
// Per-mode time totals: synchronous memory with read-modify-write and forwarding.
// Depends on ddrc_pkg; requests come from ddrc_ctrl.
`include "differential_drive_ramp_controller_top_defines.svh"

module ddrc_totals #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ddrc_pkg::t_tot_req   i_req,
    input  logic [TIME_BITS-1:0] i_delta,
    input  logic                 i_go,
    output logic [31:0]          o_report
);
    import ddrc_pkg::*;

    localparam int RW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] r_mem [NUM_MODES];
    logic [NUM_MODES-1:0] r_vld;

    t_tot_req             r_op;
    logic [TIME_BITS-1:0] r_delta;
    logic [TIME_BITS-1:0] r_rdata;
    logic                 r_rvld;
    logic                 r_fwd_hit;
    logic [TIME_BITS-1:0] r_fwd_data;

    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] total;
    logic [RW-1:0]        wide;
    logic                 wr_en;

    always_comb begin
        base  = r_fwd_hit ? r_fwd_data : (r_rvld ? r_rdata : '0);
        sum   = {1'b0, base} + {1'b0, r_delta};
        total = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        wide  = RW'(total);
        wr_en = i_go && r_op.upd;
        if (!r_op.rd) begin
            o_report = '0;
        end else if (wide > RW'(READ_MAX)) begin
            o_report = READ_MAX;
        end else begin
            o_report = wide[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_op.idx] <= total;
        end
        if (i_load) begin
            r_rdata    <= r_mem[i_req.idx];
            r_rvld     <= r_vld[i_req.idx];
            r_fwd_hit  <= wr_en && (r_op.idx == i_req.idx);
            r_fwd_data <= total;
            r_delta    <= i_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_op  <= '0;
        end else begin
            if (wr_en) begin
                r_vld[r_op.idx] <= 1'b1;
            end
            if (i_load) begin
                r_op <= i_req;
            end
        end
    end

    `DDRC_ASSERT_ALWAYS(a_req_single, !(i_req.upd && i_req.rd), "update and read in one request")
    `DDRC_ASSERT_NEXT(a_wr_marks_vld, wr_en, r_vld[$past(r_op.idx)],
        "written total not marked valid")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for differential_drive_ramp_controller_top: stream stimulus,
// random idling and stalls, and a drive-state predictor with a scoreboard. Needs ddrc_pkg.
module tb;
    import ddrc_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int WATCHDOG    = 2000;
    localparam int SETTLE      = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // direction[3:0], duration_ms[27:4], report_mode[31:28]
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // mode_now[3:0], right_power[10:4], left_power[17:11],
                                      // bridge_bits[21:18], mode_time_ms[53:22], zero[55:54]
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    differential_drive_ramp_controller_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    class drive_scoreboard;
        logic [6:0]  cruise, spin, inner, start_pwr, down;
        logic [7:0]  period;
        logic [3:0]  mode;
        logic [6:0]  r_lvl, l_lvl, r_goal, l_goal;
        logic [3:0]  bridge;
        logic [23:0] remain;
        logic [7:0]  pcount;
        logic [31:0] since;
        logic [31:0] totals [1:8];
        logic [55:0] due_results [$];
        int          errors;

        function new();
            cruise    = RST_CRUISE;
            spin      = RST_SPIN;
            inner     = RST_INNER;
            start_pwr = RST_START;
            down      = RST_DOWN;
            period    = RST_PERIOD;
            mode      = MODE_HALT;
            r_lvl     = '0;
            l_lvl     = '0;
            r_goal    = '0;
            l_goal    = '0;
            bridge    = '0;
            remain    = '0;
            pcount    = '0;
            since     = '0;
            errors    = 0;
            foreach (totals[m]) totals[m] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                CFG_CRUISE: cruise = val[6:0];
                CFG_SPIN:   spin = val[6:0];
                CFG_INNER:  inner = val[6:0];
                CFG_START:  start_pwr = val[6:0];
                CFG_DOWN:   down = val[6:0];
                CFG_PERIOD: period = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void enter_mode(logic [3:0] m);
            if (mode != MODE_HALT) totals[mode] = sat_add(totals[mode], since);
            since = '0;
            mode = m;
        endfunction

        function logic [6:0] ramp(logic [6:0] lvl, logic [6:0] goal);
            logic [7:0] up;
            if (lvl == goal) return lvl;
            if (goal < lvl) return (lvl < down) ? 7'd0 : lvl - down;
            up = (lvl < start_pwr) ? {1'b0, start_pwr} : {1'b0, lvl} + 8'd1;
            if (up > {1'b0, goal}) up = {1'b0, goal};
            return up[6:0];
        endfunction

        function void ramp_tick();
            if (remain == 0 && mode != MODE_HALT) begin
                enter_mode(MODE_HALT);
                r_goal = '0;
                l_goal = '0;
            end
            r_lvl = ramp(r_lvl, r_goal);
            l_lvl = ramp(l_lvl, l_goal);
            if (r_lvl == 0) bridge &= ~BRIDGE_RIGHT;
            if (l_lvl == 0) bridge &= ~BRIDGE_LEFT;
        endfunction

        function void move(logic [3:0] dir, logic [23:0] dur);
            if (dir > MODE_MAX) return;
            if (dir == MODE_HALT) begin
                if (mode != MODE_HALT) begin
                    enter_mode(MODE_HALT);
                    r_goal = '0;
                    l_goal = '0;
                end
                return;
            end
            if (mode != dir) begin
                enter_mode(dir);
                case (dir)
                    MODE_FWD, MODE_BWD: begin
                        r_goal = cruise;
                        l_goal = cruise;
                    end
                    MODE_SPIN_R, MODE_SPIN_L: begin
                        r_goal = spin;
                        l_goal = spin;
                    end
                    MODE_FWD_R, MODE_BWD_R: begin
                        r_goal = inner;
                        l_goal = cruise;
                    end
                    default: begin
                        r_goal = cruise;
                        l_goal = inner;
                    end
                endcase
                case (dir)
                    MODE_FWD, MODE_FWD_R, MODE_FWD_L: bridge = 4'b0101;
                    MODE_BWD, MODE_BWD_R, MODE_BWD_L: bridge = 4'b1010;
                    MODE_SPIN_R:                      bridge = 4'b0110;
                    default:                          bridge = 4'b1001;
                endcase
            end
            if (dur != 0) remain = dur;
        endfunction

        function void note_cmd(t_cmd c, logic [3:0] dir, logic [23:0] dur, logic [3:0] rep);
            logic [31:0] rpt;
            rpt = '0;
            case (c)
                CMD_TICK: begin
                    since = sat_add(since, 32'd1);
                    if (remain != 0) remain = remain - 24'd1;
                    pcount = pcount + 8'd1;
                    if (pcount >= period) begin
                        pcount = '0;
                        ramp_tick();
                    end
                end
                CMD_MOVE: move(dir, dur);
                CMD_READ: begin
                    if (rep >= MODE_FWD && rep <= MODE_BWD_L) begin
                        rpt = totals[rep];
                        if (mode == rep) rpt = sat_add(rpt, since);
                    end
                end
                default: ;
            endcase
            due_results.push_back({2'b00, rpt, bridge, l_lvl, r_lvl, mode});
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [55:0] got);
            logic [55:0] want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            compare("mode_now", want[3:0], got[3:0]);
            compare("right_power", want[10:4], got[10:4]);
            compare("left_power", want[17:11], got[17:11]);
            compare("bridge_bits", want[21:18], got[21:18]);
            compare("mode_time_ms", want[53:22], got[53:22]);
        endfunction
    endclass

    drive_scoreboard sb = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_cmd(t_cmd'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[27:4],
                            s_axis_tdata[31:28]);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                i_cfg_we) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input logic [3:0] dir, input logic [23:0] dur,
                            input logic [3:0] rep);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {rep, dur, dir};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [6:0] cruise, input logic [6:0] spin,
                              input logic [6:0] inner, input logic [6:0] start_pwr,
                              input logic [6:0] down, input logic [7:0] period);
        drive_reg(CFG_CRUISE, {1'b0, cruise});
        drive_reg(CFG_SPIN, {1'b0, spin});
        drive_reg(CFG_INNER, {1'b0, inner});
        drive_reg(CFG_START, {1'b0, start_pwr});
        drive_reg(CFG_DOWN, {1'b0, down});
        drive_reg(CFG_PERIOD, period);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int hold_at, input int drain_at);
        t_cmd        c;
        int          roll;
        logic [3:0]  dir;
        logic [3:0]  rep;
        logic [23:0] dur;
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) hold_reqs <= hold_reqs + 1;
            if (k == drain_at) wait_drained();
            roll = $urandom_range(99);
            c = (roll < 55) ? CMD_TICK : (roll < 77) ? CMD_MOVE : (roll < 92) ? CMD_READ : CMD_IDLE;
            roll = $urandom_range(99);
            dir = (roll < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
            roll = $urandom_range(99);
            dur = (roll < 15) ? 24'd0 : (roll < 85) ? 24'($urandom_range(64, 1)) : 24'($urandom);
            roll = $urandom_range(99);
            rep = (roll < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
            send_cmd(c, dir, dur, rep);
        end
    endtask

    task automatic run_directed();
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_HALT);
        send_cmd(CMD_READ, 4'hF, 24'hFFFFFF, 4'hF);
        send_cmd(CMD_IDLE, 4'hF, 24'hFFFFFF, 4'hF);
        send_cmd(CMD_MOVE, 4'hF, 24'd9, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_HALT, 24'd9, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_FWD, 24'd0, MODE_FWD);
        repeat (3) send_cmd(CMD_TICK, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_FWD, 24'hFFFFFF, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_SPIN_R, 24'd1, MODE_FWD);
        send_cmd(CMD_TICK, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_SPIN_R);
        send_cmd(CMD_MOVE, MODE_BWD, 24'd2, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_SPIN_L, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_FWD_R, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_FWD_L, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_BWD_R, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_BWD_L, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_HALT, 24'd100, MODE_FWD);
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_BWD_L);
        wait_drained();
        // zero ramp period and zero down step
        set_config(7'd100, 7'd0, 7'd0, 7'd100, 7'd0, 8'd0);
        send_cmd(CMD_MOVE, MODE_FWD_R, 24'd3, MODE_FWD);
        repeat (2) send_cmd(CMD_TICK, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_MOVE, MODE_BWD_R, 24'd0, MODE_FWD);
        repeat (2) send_cmd(CMD_TICK, MODE_HALT, 24'd0, MODE_FWD);
        send_cmd(CMD_READ, MODE_HALT, 24'd0, MODE_BWD_R);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_drained();

        set_config(7'd75, 7'd50, 7'd8, 7'd30, 7'd5, 8'd1);
        idle_pct = 0;
        stall_pct <= 0;
        run_random(270, 80, 180);
        wait_drained();

        set_config(7'd100, 7'd100, 7'd0, 7'd0, 7'd1, 8'd2);
        idle_pct = 73;
        stall_pct <= 0;
        run_random(270, -1, -1);
        wait_drained();

        set_config(7'd0, 7'd37, 7'd100, 7'd100, 7'd100, 8'd0);
        idle_pct = 0;
        stall_pct <= 73;
        run_random(270, -1, -1);
        wait_drained();

        set_config(7'($urandom_range(100)), 7'($urandom_range(100)), 7'($urandom_range(100)),
                   7'($urandom_range(100)), 7'($urandom_range(100, 1)),
                   8'($urandom_range(6, 1)));
        idle_pct = 32;
        stall_pct <= 32;
        run_random(200, -1, -1);
        wait_drained();

        set_config(7'd60, 7'd40, 7'd20, 7'd10, 7'd7, 8'd255);
        run_random(60, -1, -1);
        wait_drained();

        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/ddrc_pkg.sv
rtl/ddrc_ctrl.sv
rtl/ddrc_totals.sv
rtl/differential_drive_ramp_controller_top.sv
tb/tb.sv
